// File: hdl/vilc_pkg.sv
// Shared types, constants and helpers for the vectored interrupt level controller.
// No dependencies.
package vilc_pkg;

   localparam int LEVEL_W  = 3;
   localparam int VECTOR_W = 8;

   localparam int DEF_NUM_CPUS     = 2;
   localparam int DEF_NUM_VECTORS  = 256;
   localparam int DEF_FIRST_VECTOR = 16;

   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [VECTOR_W-1:0] vector_type;

   localparam logic       REQ_SET     = 1'b0;
   localparam logic       REQ_ACK     = 1'b1;
   localparam vector_type NONE_VECTOR = 8'd15;

   typedef struct packed {
      logic      start;
      logic      valid;
      level_type target;
   } scan_ctl_type;

   typedef struct packed {
      logic       any_match;
      logic       two_match;
      vector_type match_vec;
      level_type  max_other;
      level_type  max_other_x15;
   } scan_res_type;

   function automatic level_type lvl_max(input level_type a, input level_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

// File: hdl/vilc_level_ram.sv
// Level table storage: one write port, one read port, registered read data.
// Depends on vilc_pkg.
module vilc_level_ram #(
   parameter int ADDR_W = 9
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  vilc_pkg::level_type wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output vilc_pkg::level_type rd_data
);
   import vilc_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   level_type mem [DEPTH];
   level_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/vilc_scan.sv
// Scan accumulator: tracks the last matching vector and the highest other levels
// as table words stream by. Depends on vilc_pkg.
module vilc_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  vilc_pkg::scan_ctl_type ctl,
   input  vilc_pkg::level_type    data_level,
   input  vilc_pkg::vector_type   data_vector,
   output vilc_pkg::scan_res_type res
);
   import vilc_pkg::*;

   scan_res_type res_ff;
   scan_res_type res_in;
   logic         hit;

   always_comb begin
      res_in = res_ff;
      hit    = (data_level == ctl.target);
      if (ctl.start) begin
         res_in = '0;
      end else if (ctl.valid) begin
         if (hit) begin
            res_in.any_match = 1'b1;
            res_in.two_match = res_ff.any_match;
            res_in.match_vec = data_vector;
         end else begin
            res_in.max_other = lvl_max(res_ff.max_other, data_level);
            if (data_vector != NONE_VECTOR) begin
               res_in.max_other_x15 = lvl_max(res_ff.max_other_x15, data_level);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// File: hdl/vectored_interrupt_level_controller.sv
// Top level: request sequencer around the level table and the scan accumulator.
// Depends on vilc_pkg, vilc_level_ram, vilc_scan.
//
//  channel   ports                                             handshake
//  --------  ------------------------------------------------  --------------------
//  request   req_type req_cpu req_vector req_level             start & !busy
//  result    rsp_irq_level rsp_ack_vector rsp_entry_changed    rsp_valid, 1 cycle
//  register  csr_wr_data (self-clear level)                    csr_wr_en
//
// Set item: ST_SET_RD reads the entry, ST_SET_WR writes it if changed, then ST_SCAN,
// ST_DRAIN and ST_RESULT follow; acknowledge item: ST_SCAN, ST_DRAIN, ST_RESULT. The
// single-read-port table scan reads one entry per cycle from FIRST_SCANNED_VECTOR.
// After reset the table is zeroed one entry per cycle, all 2**(CPU_AW + VEC_AW)
// entries (512 by default), with busy high; register writes still go in.
// Results are a one-cycle strobe; the receiver cannot stall them.
module vectored_interrupt_level_controller #(
   parameter int NUM_CPUS             = vilc_pkg::DEF_NUM_CPUS,
   parameter int NUM_VECTORS          = vilc_pkg::DEF_NUM_VECTORS,
   parameter int FIRST_SCANNED_VECTOR = vilc_pkg::DEF_FIRST_VECTOR
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_type,
   input  logic                 req_cpu,
   input  vilc_pkg::vector_type req_vector,
   input  vilc_pkg::level_type  req_level,
   output logic                 rsp_valid,
   output vilc_pkg::level_type  rsp_irq_level,
   output vilc_pkg::vector_type rsp_ack_vector,
   output logic                 rsp_entry_changed,
   input  logic                 csr_wr_en,
   input  vilc_pkg::level_type  csr_wr_data
);
   import vilc_pkg::*;

   localparam int VEC_AW = $clog2(NUM_VECTORS);
   localparam int CPU_AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int MEM_AW = CPU_AW + VEC_AW;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_RD,
      ST_SET_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   state_type          state_ff, state_in;
   logic [MEM_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [VEC_AW-1:0]  scan_vec_ff, scan_vec_in;
   logic [VEC_AW-1:0]  data_vec_ff, data_vec_in;
   logic               data_valid_ff, data_valid_in;
   logic               type_ff, type_in;
   logic               cpu_ff, cpu_in;
   vector_type         vector_ff, vector_in;
   level_type          level_ff, level_in;
   logic               cpu_ok_ff, cpu_ok_in;
   logic               vec_ok_ff, vec_ok_in;
   logic               changed_ff, changed_in;
   level_type          self_clear_ff, self_clear_in;
   logic               rsp_valid_ff, rsp_valid_in;
   level_type          rsp_irq_ff, rsp_irq_in;
   vector_type         rsp_ack_ff, rsp_ack_in;
   logic               rsp_changed_ff, rsp_changed_in;

   logic               wr_en;
   logic [MEM_AW-1:0]  wr_addr;
   level_type          wr_data;
   logic [MEM_AW-1:0]  rd_addr;
   level_type          rd_data;
   logic [CPU_AW-1:0]  cpu_idx;

   scan_ctl_type       scan_ctl;
   scan_res_type       scan_res;

   logic               accept;
   logic               clear_hit;
   vector_type         ack_vec;
   level_type          irq_calc;

   vilc_level_ram #(
      .ADDR_W (MEM_AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vilc_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .data_level  (rd_data),
      .data_vector (VECTOR_W'(data_vec_ff)),
      .res         (scan_res)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign cpu_idx = CPU_AW'(cpu_ff);

   assign scan_ctl.start  = (state_ff == ST_IDLE) || (state_ff == ST_SET_RD) ||
                            (state_ff == ST_SET_WR);
   assign scan_ctl.valid  = data_valid_ff;
   assign scan_ctl.target = level_ff;

   assign rd_addr = (state_ff == ST_SCAN) ? {cpu_idx, scan_vec_ff}
                                          : {cpu_idx, vector_ff[VEC_AW-1:0]};

   assign clear_hit = (type_ff == REQ_ACK) && (level_ff == self_clear_ff);
   assign ack_vec   = scan_res.any_match ? scan_res.match_vec : NONE_VECTOR;

   always_comb begin
      if (clear_hit && !scan_res.any_match) begin
         irq_calc = scan_res.max_other_x15;
      end else if (clear_hit) begin
         irq_calc = lvl_max(scan_res.max_other, scan_res.two_match ? level_ff : '0);
      end else begin
         irq_calc = lvl_max(scan_res.max_other, scan_res.any_match ? level_ff : '0);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {cpu_idx, vector_ff[VEC_AW-1:0]};
      wr_data = level_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
         end
         ST_SET_WR: begin
            wr_en = (rd_data != level_ff);
         end
         ST_RESULT: begin
            wr_en   = cpu_ok_ff && clear_hit;
            wr_addr = {cpu_idx, ack_vec[VEC_AW-1:0]};
            wr_data = '0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      scan_vec_in    = scan_vec_ff;
      data_vec_in    = scan_vec_ff;
      data_valid_in  = (state_ff == ST_SCAN);
      type_in        = type_ff;
      cpu_in         = cpu_ff;
      vector_in      = vector_ff;
      level_in       = level_ff;
      cpu_ok_in      = cpu_ok_ff;
      vec_ok_in      = vec_ok_ff;
      changed_in     = changed_ff;
      self_clear_in  = csr_wr_en ? csr_wr_data : self_clear_ff;
      rsp_valid_in   = 1'b0;
      rsp_irq_in     = rsp_irq_ff;
      rsp_ack_in     = rsp_ack_ff;
      rsp_changed_in = rsp_changed_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               type_in     = req_type;
               cpu_in      = req_cpu;
               vector_in   = req_vector;
               level_in    = req_level;
               cpu_ok_in   = (32'(req_cpu) < NUM_CPUS);
               vec_ok_in   = (32'(req_vector) < NUM_VECTORS);
               changed_in  = 1'b0;
               scan_vec_in = VEC_AW'(FIRST_SCANNED_VECTOR);
               if (32'(req_cpu) >= NUM_CPUS) begin
                  state_in = ST_RESULT;
               end else if (req_type == REQ_SET && 32'(req_vector) < NUM_VECTORS) begin
                  state_in = ST_SET_RD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SET_RD: begin
            state_in = ST_SET_WR;
         end
         ST_SET_WR: begin
            changed_in = (rd_data != level_ff);
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            scan_vec_in = scan_vec_ff + 1'b1;
            if (scan_vec_ff == VEC_AW'(NUM_VECTORS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            rsp_valid_in = 1'b1;
            if (cpu_ok_ff) begin
               rsp_irq_in     = irq_calc;
               rsp_ack_in     = (type_ff == REQ_ACK) ? ack_vec : '0;
               rsp_changed_in = (type_ff == REQ_SET) && vec_ok_ff && changed_ff;
            end else begin
               rsp_irq_in     = '0;
               rsp_ack_in     = '0;
               rsp_changed_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         data_valid_ff <= 1'b0;
         self_clear_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         data_valid_ff <= data_valid_in;
         self_clear_ff <= self_clear_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_vec_ff    <= scan_vec_in;
      data_vec_ff    <= data_vec_in;
      type_ff        <= type_in;
      cpu_ff         <= cpu_in;
      vector_ff      <= vector_in;
      level_ff       <= level_in;
      cpu_ok_ff      <= cpu_ok_in;
      vec_ok_ff      <= vec_ok_in;
      changed_ff     <= changed_in;
      rsp_irq_ff     <= rsp_irq_in;
      rsp_ack_ff     <= rsp_ack_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_irq_level     = rsp_irq_ff;
   assign rsp_ack_vector    = rsp_ack_ff;
   assign rsp_entry_changed = rsp_changed_ff;

   a_rsp_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not make the block busy");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && state_ff == ST_IDLE && $past(state_ff) == ST_RESULT))
      else $error("result shown outside the result step");

   a_changed_only_on_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_changed) |-> (rsp_ack_vector == '0))
      else $error("entry change reported with an acknowledge vector");

endmodule
